// ===== src/assert_macros.svh =====
// Assertion macros for the RTL decoder unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== src/ps2kd_pkg.sv =====
// Types, scan codes and key map for the PS/2 key event decoder.
`default_nettype none
package ps2kd_pkg;

   localparam int KEY_COUNT = 9;

   typedef logic [7:0]           scan_byte_type;
   typedef logic [3:0]           key_code_type;
   typedef logic [KEY_COUNT-1:0] key_mask_type;

   localparam scan_byte_type PREFIX_EXTENDED = 8'hE0;
   localparam scan_byte_type PREFIX_BREAK    = 8'hF0;

   localparam scan_byte_type MAKE_UP    = 8'h75;
   localparam scan_byte_type MAKE_DOWN  = 8'h72;
   localparam scan_byte_type MAKE_LEFT  = 8'h6B;
   localparam scan_byte_type MAKE_RIGHT = 8'h74;
   localparam scan_byte_type MAKE_SPACE = 8'h29;
   localparam scan_byte_type MAKE_ENTER = 8'h5A;
   localparam scan_byte_type MAKE_ESC   = 8'h76;
   localparam scan_byte_type MAKE_PLUS  = 8'h79;
   localparam scan_byte_type MAKE_MINUS = 8'h4E;

   localparam key_code_type KC_UP    = 4'd0;
   localparam key_code_type KC_DOWN  = 4'd1;
   localparam key_code_type KC_LEFT  = 4'd2;
   localparam key_code_type KC_RIGHT = 4'd3;
   localparam key_code_type KC_SPACE = 4'd4;
   localparam key_code_type KC_ENTER = 4'd5;
   localparam key_code_type KC_ESC   = 4'd6;
   localparam key_code_type KC_PLUS  = 4'd7;
   localparam key_code_type KC_MINUS = 4'd8;
   localparam key_code_type NO_KEY   = 4'd15;

   function automatic key_code_type lookup_key(input logic ext, input scan_byte_type code);
      key_code_type k;
      k = NO_KEY;
      if (ext) begin
         case (code)
            MAKE_UP:    k = KC_UP;
            MAKE_DOWN:  k = KC_DOWN;
            MAKE_LEFT:  k = KC_LEFT;
            MAKE_RIGHT: k = KC_RIGHT;
            default:    k = NO_KEY;
         endcase
      end else begin
         case (code)
            MAKE_SPACE: k = KC_SPACE;
            MAKE_ENTER: k = KC_ENTER;
            MAKE_ESC:   k = KC_ESC;
            MAKE_PLUS:  k = KC_PLUS;
            MAKE_MINUS: k = KC_MINUS;
            default:    k = NO_KEY;
         endcase
      end
      return k;
   endfunction

   // One-hot held-bit mask for a key; zero for codes outside the map.
   function automatic key_mask_type key_bit(input key_code_type k);
      key_mask_type m;
      m = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (k == key_code_type'(i)) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== src/ps2_key_event_decoder_unit.sv =====
// A scan byte is registered in the input register; its result is registered in the result register.
// Throughput: one scan byte per cycle; a byte stalls only while the result register
// holds an untaken result and the byte would produce a new one.
// Prefix bytes, unknown codes and repeated presses produce no result and never stall.
// Reset (synchronous, active high) clears both prefix flags, all held bits and
// both valid registers.
`default_nettype none
`include "assert_macros.svh"
module ps2_key_event_decoder_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire ps2kd_pkg::scan_byte_type req_scan_byte,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      ps2kd_pkg::key_code_type rsp_key_code,
   output      logic                    rsp_is_release
);
   import ps2kd_pkg::*;

   logic          in_valid_ff, in_valid_in;
   scan_byte_type in_byte_ff, in_byte_in;
   logic          ext_ff, ext_in;
   logic          brk_ff, brk_in;
   key_mask_type  held_ff, held_in;
   logic          out_valid_ff, out_valid_in;
   key_code_type  out_key_ff, out_key_in;
   logic          out_rel_ff, out_rel_in;

   logic          is_ext_prefix, is_brk_prefix;
   key_code_type  key;
   key_mask_type  mask;
   logic          emit;
   logic          slot_free;
   logic          advance;

   always_comb begin
      is_ext_prefix = (in_byte_ff == PREFIX_EXTENDED);
      is_brk_prefix = (in_byte_ff == PREFIX_BREAK);
      key           = lookup_key(ext_ff, in_byte_ff);
      mask          = key_bit(key);
      // release always reports; press only when the key was not held
      emit          = !is_ext_prefix && !is_brk_prefix && (key != NO_KEY) &&
                      (brk_ff || ((held_ff & mask) == '0));
      slot_free     = !out_valid_ff || rsp_ready;
      advance       = in_valid_ff && (!emit || slot_free);
   end

   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      ext_in       = ext_ff;
      brk_in       = brk_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_key_in   = out_key_ff;
      out_rel_in   = out_rel_ff;

      if (advance) begin
         in_valid_in = 1'b0;
         if (is_ext_prefix) begin
            ext_in = 1'b1;
         end else if (is_brk_prefix) begin
            brk_in = 1'b1;
         end else begin
            ext_in = 1'b0;
            brk_in = 1'b0;
            if (key != NO_KEY) begin
               held_in = brk_ff ? (held_ff & ~mask) : (held_ff | mask);
            end
            if (emit) begin
               out_valid_in = 1'b1;
               out_key_in   = key;
               out_rel_in   = brk_ff;
            end
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ext_ff       <= 1'b0;
         brk_ff       <= 1'b0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         ext_ff       <= ext_in;
         brk_ff       <= brk_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_key_ff <= out_key_in;
      out_rel_ff <= out_rel_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_code   = out_key_ff;
   assign rsp_is_release = out_rel_ff;

   `ASSERT_IMPL(a_key_in_map, clock, reset, rsp_valid, rsp_key_code <= KC_MINUS)
   `ASSERT_IMPL(a_press_held, clock, reset, rsp_valid && !rsp_is_release,
                (held_ff & key_bit(rsp_key_code)) != '0)
   `ASSERT_IMPL(a_release_clear, clock, reset, rsp_valid && rsp_is_release,
                (held_ff & key_bit(rsp_key_code)) == '0)
   `ASSERT_NEXT(a_flags_clear, clock, reset,
                advance && !is_ext_prefix && !is_brk_prefix, !ext_ff && !brk_ff)

endmodule
`default_nettype wire

// ===== test/ps2_key_event_decoder_unit_test.sv =====
// Self-checking testbench for the PS/2 scan byte to key event decoder.
`timescale 1ns / 1ps
module ps2_key_event_decoder_unit_test;
   import ps2kd_pkg::*;

   localparam int FIRST_PLAIN_KEY = 4;        // keys below this need the extended prefix
   localparam int HOLD_OFF_CYCLES = 250;
   localparam scan_byte_type LOWEST_BYTE  = 8'h00;
   localparam scan_byte_type HIGHEST_BYTE = 8'hFF;

   localparam logic BY_TABLE     = 1'b1;
   localparam logic BY_PREDICTOR = 1'b0;
   localparam logic EVENT        = 1'b1;
   localparam logic NO_EVENT     = 1'b0;
   localparam logic PRESS        = 1'b0;
   localparam logic RELEASE      = 1'b1;

   typedef struct packed {
      key_code_type key;
      logic         rel;
   } key_event_type;

   typedef struct packed {
      scan_byte_type code;
      logic          typed;
      logic          has_event;
      key_code_type  key;
      logic          rel;
   } scan_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   scan_byte_type req_scan_byte = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   key_code_type  rsp_key_code;
   logic          rsp_is_release;

   // decoder state mirror
   logic         ext_seen = 1'b0;
   logic         brk_seen = 1'b0;
   key_mask_type held = '0;

   key_event_type pending_events [$];
   int mismatch_count = 0;
   int sent_count = 0;
   int req_idle_pct = 28;
   int rsp_idle_pct = 28;
   int hold_left = 0;
   bit hold_request = 1'b0;

   scan_byte_type scan_of_key [KEY_COUNT] = '{MAKE_UP, MAKE_DOWN, MAKE_LEFT, MAKE_RIGHT,
      MAKE_SPACE, MAKE_ENTER, MAKE_ESC, MAKE_PLUS, MAKE_MINUS};

   scan_row_type directed_rows [29] = '{
      '{LOWEST_BYTE,     BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{HIGHEST_BYTE,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_SPACE,      BY_TABLE,     EVENT,    KC_SPACE, PRESS},
      '{MAKE_SPACE,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},   // typematic repeat
      '{PREFIX_BREAK,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_SPACE,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_BREAK,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_SPACE,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},   // release, not held
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_UP,         BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_BREAK,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_BREAK,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_UP,         BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_BREAK,    BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},   // break before extended
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_DOWN,       BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_SPACE,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},   // plain key after E0
      '{MAKE_UP,         BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},   // extended code, no E0
      '{MAKE_ENTER,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_ESC,        BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_PLUS,       BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_MINUS,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_LEFT,       BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS},
      '{PREFIX_EXTENDED, BY_TABLE,     NO_EVENT, NO_KEY,   PRESS},
      '{MAKE_RIGHT,      BY_PREDICTOR, NO_EVENT, NO_KEY,   PRESS}
   };

   ps2_key_event_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_scan_byte  (req_scan_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_code   (rsp_key_code),
      .rsp_is_release (rsp_is_release)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Advance the state mirror by one accepted byte; got is set when a key event follows.
   task automatic advance_decoder(input scan_byte_type b, output logic got,
                                  output key_event_type ev);
      key_code_type k;
      logic found;
      got = 1'b0;
      ev = '0;
      found = 1'b0;
      k = NO_KEY;
      if (b == PREFIX_EXTENDED) begin
         ext_seen = 1'b1;
      end else if (b == PREFIX_BREAK) begin
         brk_seen = 1'b1;
      end else begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            if (scan_of_key[i] == b && ((i < FIRST_PLAIN_KEY) == ext_seen)) begin
               found = 1'b1;
               k = key_code_type'(i);
            end
         end
         if (found) begin
            if (brk_seen) begin
               held[k] = 1'b0;
               got = 1'b1;
               ev = '{k, RELEASE};
            end else if (!held[k]) begin
               held[k] = 1'b1;
               got = 1'b1;
               ev = '{k, PRESS};
            end
         end
         ext_seen = 1'b0;
         brk_seen = 1'b0;
      end
   endtask

   // Offer one byte and wait for the transfer; the mirror advances at that edge.
   task automatic send_byte(input scan_byte_type b, output logic got,
                            output key_event_type ev);
      req_valid <= 1'b1;
      req_scan_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      advance_decoder(b, got, ev);
   endtask

   // Maybe drop valid for a random idle gap; expectations are queued before this.
   task automatic idle_gap();
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
   endtask

   task automatic send_predicted(input scan_byte_type b);
      logic got;
      key_event_type ev;
      send_byte(b, got, ev);
      if (got) pending_events.push_back(ev);
      idle_gap();
   endtask

   task automatic send_random_sequence();
      int pick;
      int k;
      int n;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, KEY_COUNT - 1);
      if (pick < 75) begin
         if (k < FIRST_PLAIN_KEY) send_predicted(PREFIX_EXTENDED);
         if ($urandom_range(0, 1)) send_predicted(PREFIX_BREAK);
         send_predicted(scan_of_key[k]);
      end else if (pick < 85) begin
         send_predicted(scan_byte_type'($urandom_range(0, 255)));
      end else if (pick < 93) begin
         // prefix followed by a code of either class or noise
         send_predicted($urandom_range(0, 1) ? PREFIX_EXTENDED : PREFIX_BREAK);
         send_predicted($urandom_range(0, 1) ? scan_of_key[k]
                                             : scan_byte_type'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(2, 5);
         repeat (n) send_predicted($urandom_range(0, 1) ? PREFIX_EXTENDED : PREFIX_BREAK);
         send_predicted(scan_of_key[k]);
      end
   endtask

   // Result side: check transfers, then pick next ready.
   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event key %0d release %0b",
                                      rsp_key_code, rsp_is_release));
         end else begin
            want = pending_events.pop_front();
            if (rsp_key_code !== want.key)
               report_mismatch($sformatf("key_code %0d, wanted %0d", rsp_key_code, want.key));
            if (rsp_is_release !== want.rel)
               report_mismatch($sformatf("is_release %0b, wanted %0b (key %0d)",
                                         rsp_is_release, want.rel, want.key));
         end
      end
      if (hold_left == 0 && hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      logic got;
      key_event_type ev;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].code, got, ev);
         if (directed_rows[i].typed) begin
            if (directed_rows[i].has_event)
               pending_events.push_back('{directed_rows[i].key, directed_rows[i].rel});
         end else if (got) begin
            pending_events.push_back(ev);
         end
         idle_gap();
      end

      while (sent_count < 430) send_random_sequence();

      // stretch with no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (sent_count < 730) send_random_sequence();

      // receiver stalls while the sender keeps offering
      hold_request = 1'b1;
      while (sent_count < 830) send_random_sequence();

      req_idle_pct = 28;
      rsp_idle_pct = 28;
      while (sent_count < 1130) send_random_sequence();
      req_valid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
